// ===== hw/rtl/leb_pkg.sv =====
package leb_pkg;

    localparam int LINE_SIZE_DEF = 128;
    localparam int CHAR_W        = 8;
    localparam int CNT_W         = 7;

    localparam logic [CHAR_W-1:0] KEY_RIGHT     = 8'd67;
    localparam logic [CHAR_W-1:0] KEY_LEFT      = 8'd68;
    localparam logic [CHAR_W-1:0] KEY_HOME      = 8'd72;
    localparam logic [CHAR_W-1:0] KEY_END       = 8'd70;
    localparam logic [CHAR_W-1:0] KEY_DELETE    = 8'd66;
    localparam logic [CHAR_W-1:0] KEY_BACKSPACE = 8'd127;
    localparam logic [CHAR_W-1:0] KEY_ENTER     = 8'd10;

    localparam logic [1:0] OP_HOLD = 2'd0;
    localparam logic [1:0] OP_PUSH = 2'd1;
    localparam logic [1:0] OP_POP  = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [CHAR_W-1:0] data;
    } stk_ctl_t;

endpackage

// ===== hw/rtl/leb_if.sv =====
interface leb_key_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_code;

    modport source (output valid, output key_code, input ready);
    modport sink (input valid, input key_code, output ready);
endinterface

interface leb_res_if;
    logic       valid;
    logic       ready;
    logic [6:0] cursor_pos;
    logic [6:0] line_length;
    logic [7:0] char_at_cursor;
    logic       finished;

    modport source (output valid, output cursor_pos, output line_length,
                    output char_at_cursor, output finished, input ready);
    modport sink (input valid, input cursor_pos, input line_length,
                  input char_at_cursor, input finished, output ready);
endinterface

// ===== hw/rtl/line_edit_buffer_unit.sv =====
// Single-line edit buffer with a cursor, one key code per transaction. The text
// is held as two cell rows of LINE_SIZE-1 characters each: the row left of the
// cursor (top = character before it) and the row from the cursor on (top =
// character at it), so every edit is a push or pop on one or both rows. Right,
// left, delete, backspace, enter and character keys give a registered result in
// the cycle after acceptance. Home and end walk the cursor one position per
// cycle through the rows and give their result once the walk reaches the start
// or end of the line. A new key is accepted once the previous one is finished
// and its result is taken or being taken in the same cycle. Counts wider than 7
// bits are reported modulo 128.
module line_edit_buffer_unit #(
    parameter int LINE_SIZE = leb_pkg::LINE_SIZE_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    leb_key_if.sink   key,
    leb_res_if.source res
);
    import leb_pkg::*;

    localparam int PTR_W = $clog2(LINE_SIZE);

    localparam logic ST_RUN  = 1'b0;
    localparam logic ST_SEEK = 1'b1;

    logic             state_reg, state_next;
    logic             dir_reg, dir_next;     // 1: toward end
    logic [PTR_W-1:0] cursor_reg, cursor_next;
    logic [PTR_W-1:0] length_reg, length_next;

    logic             res_valid_reg, res_valid_next;
    logic [CNT_W-1:0] cursor_pos_reg;
    logic [CNT_W-1:0] line_length_reg;
    logic [CHAR_W-1:0] char_reg;
    logic             finished_reg;

    stk_ctl_t          l_ctl, r_ctl;
    logic [CHAR_W-1:0] l_top, l_second, r_top, r_second, r_top_next;
    logic              accept, load, done;
    logic              at_start, at_end, room;

    leb_stack #(.DEPTH(LINE_SIZE - 1)) u_left (
        .clk    (clk),
        .ctl    (l_ctl),
        .top    (l_top),
        .second (l_second)
    );

    leb_stack #(.DEPTH(LINE_SIZE - 1)) u_right (
        .clk    (clk),
        .ctl    (r_ctl),
        .top    (r_top),
        .second (r_second)
    );

    assign key.ready = (state_reg == ST_RUN) && (!res_valid_reg || res.ready);
    assign accept    = key.valid && key.ready;

    assign at_start = (cursor_reg == '0);
    assign at_end   = (cursor_reg == length_reg);
    assign room     = ({1'b0, length_reg} + 1'b1) < (PTR_W+1)'(LINE_SIZE);

    always_comb
    begin
        l_ctl       = '{op: OP_HOLD, data: r_top};
        r_ctl       = '{op: OP_HOLD, data: l_top};
        cursor_next = cursor_reg;
        length_next = length_reg;
        state_next  = state_reg;
        dir_next    = dir_reg;
        load        = 1'b0;
        done        = 1'b0;

        unique case (state_reg)
            ST_RUN:
            begin
                if (accept) begin
                    load = 1'b1;
                    unique case (key.key_code) inside
                        KEY_RIGHT:
                        begin
                            if (!at_end) begin
                                l_ctl.op    = OP_PUSH;
                                r_ctl.op    = OP_POP;
                                cursor_next = cursor_reg + 1'b1;
                            end
                        end
                        KEY_LEFT:
                        begin
                            if (!at_start) begin
                                l_ctl.op    = OP_POP;
                                r_ctl.op    = OP_PUSH;
                                cursor_next = cursor_reg - 1'b1;
                            end
                        end
                        KEY_HOME, KEY_END:
                        begin
                            load       = 1'b0;
                            state_next = ST_SEEK;
                            dir_next   = (key.key_code == KEY_END);
                        end
                        KEY_DELETE:
                        begin
                            if (!at_end) begin
                                r_ctl.op    = OP_POP;
                                length_next = length_reg - 1'b1;
                            end
                        end
                        KEY_BACKSPACE:
                        begin
                            if (!at_start) begin
                                l_ctl.op    = OP_POP;
                                cursor_next = cursor_reg - 1'b1;
                                length_next = length_reg - 1'b1;
                            end
                        end
                        KEY_ENTER:
                        begin
                            done = 1'b1;
                        end
                        default:
                        begin
                            if (room) begin
                                l_ctl.op    = OP_PUSH;
                                l_ctl.data  = key.key_code;
                                cursor_next = cursor_reg + 1'b1;
                                // overwrite drops the old char at the cursor
                                if (!at_end) begin
                                    r_ctl.op = OP_POP;
                                end else begin
                                    length_next = length_reg + 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_SEEK:
            begin
                if (dir_reg ? at_end : at_start) begin
                    load       = 1'b1;
                    state_next = ST_RUN;
                end else if (dir_reg) begin
                    l_ctl.op    = OP_PUSH;
                    r_ctl.op    = OP_POP;
                    cursor_next = cursor_reg + 1'b1;
                end else begin
                    l_ctl.op    = OP_POP;
                    r_ctl.op    = OP_PUSH;
                    cursor_next = cursor_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_comb
    begin
        unique case (r_ctl.op)
            OP_PUSH: r_top_next = r_ctl.data;
            OP_POP:  r_top_next = r_second;
            default: r_top_next = r_top;
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (load) begin
            res_valid_next = 1'b1;
        end else if (res.ready) begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_RUN;
            dir_reg       <= 1'b0;
            cursor_reg    <= '0;
            length_reg    <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            dir_reg       <= dir_next;
            cursor_reg    <= cursor_next;
            length_reg    <= length_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            cursor_pos_reg  <= CNT_W'(cursor_next);
            line_length_reg <= CNT_W'(length_next);
            char_reg        <= (cursor_next < length_next) ? r_top_next : '0;
            finished_reg    <= done;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.cursor_pos     = cursor_pos_reg;
    assign res.line_length    = line_length_reg;
    assign res.char_at_cursor = char_reg;
    assign res.finished       = finished_reg;

endmodule

// ===== hw/rtl/leb_cell.sv =====
module leb_cell (
    input  logic       clk,
    input  logic [1:0] op,
    input  logic [7:0] above,
    input  logic [7:0] below,
    output logic [7:0] q
);
    import leb_pkg::*;

    logic [CHAR_W-1:0] q_reg;
    logic [CHAR_W-1:0] q_next;

    always_comb
    begin
        unique case (op)
            OP_PUSH: q_next = above;
            OP_POP:  q_next = below;
            default: q_next = q_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// ===== hw/rtl/leb_stack.sv =====
module leb_stack #(
    parameter int DEPTH = leb_pkg::LINE_SIZE_DEF - 1
) (
    input  logic             clk,
    input  leb_pkg::stk_ctl_t ctl,
    output logic [7:0]       top,
    output logic [7:0]       second
);
    import leb_pkg::*;

    logic [CHAR_W-1:0] q [DEPTH];

    // Cell 0 is the top of the stack; a push ripples every cell one deeper.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [CHAR_W-1:0] above;
        logic [CHAR_W-1:0] below;

        if (i == 0) begin : g_top
            assign above = ctl.data;
        end else begin : g_mid
            assign above = q[i-1];
        end

        if (i == DEPTH - 1) begin : g_bot
            assign below = '0;
        end else begin : g_up
            assign below = q[i+1];
        end

        leb_cell u_cell (
            .clk   (clk),
            .op    (ctl.op),
            .above (above),
            .below (below),
            .q     (q[i])
        );
    end

    assign top    = q[0];
    assign second = q[1];

endmodule

// ===== bench/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import leb_pkg::*;

    localparam int LINE_CELLS  = LINE_SIZE_DEF;
    localparam int RANDOM_KEYS = 1500;
    localparam int FILL_KEYS   = 130;
    localparam int DRAIN_WAIT  = 300;

    // up arrow has no edit function and lands as a character
    localparam logic [CHAR_W-1:0] KEY_UP = 8'd65;

    typedef struct packed {
        logic [CNT_W-1:0]  cursor_pos;
        logic [CNT_W-1:0]  line_length;
        logic [CHAR_W-1:0] char_at_cursor;
        logic              finished;
    } line_res_t;

    typedef struct packed {
        logic [CHAR_W-1:0] key;
        logic              fixed;
        line_res_t         res;
    } key_row_t;

    typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_MIXED} key_mix_t;

    logic clk = 1'b0;
    logic rst_n;

    leb_key_if key_ch ();
    leb_res_if res_ch ();

    line_edit_buffer_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .key   (key_ch),
        .res   (res_ch)
    );

    always #5 clk = ~clk;

    // Shadow copy of the edit buffer.
    logic [CHAR_W-1:0] line_cells [LINE_CELLS];
    int                edit_cursor;
    int                line_len;

    key_row_t  key_plan [$];
    line_res_t pending_q [$];
    bit        plan_built;
    int        keys_accepted;
    int        results_seen;
    int        mismatches;

    initial begin
        for (int i = 0; i < LINE_CELLS; i++)
            line_cells[i] = '0;
        edit_cursor   = 0;
        line_len      = 0;
        plan_built    = 1'b0;
        keys_accepted = 0;
        results_seen  = 0;
        mismatches    = 0;
    end

    function automatic bit is_control(logic [CHAR_W-1:0] k);
        return k == KEY_RIGHT || k == KEY_LEFT || k == KEY_HOME || k == KEY_END ||
               k == KEY_DELETE || k == KEY_BACKSPACE || k == KEY_ENTER;
    endfunction

    function automatic key_row_t mk_row(logic [CHAR_W-1:0] k, logic fixed,
                                        logic [CNT_W-1:0] c, logic [CNT_W-1:0] l,
                                        logic [CHAR_W-1:0] ch, logic f);
        key_row_t r;
        r.key                = k;
        r.fixed              = fixed;
        r.res.cursor_pos     = c;
        r.res.line_length    = l;
        r.res.char_at_cursor = ch;
        r.res.finished       = f;
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] random_char();
        logic [CHAR_W-1:0] k;
        int                r;
        r = int'($urandom_range(0, 99));
        if (r < 5)
            return KEY_UP;
        k = 8'($urandom_range(0, 255));
        if (r < 92)
            while (is_control(k))
                k = 8'($urandom_range(0, 255));
        return k;
    endfunction

    function automatic logic [CHAR_W-1:0] pick_key(key_mix_t mix);
        int r;
        int c_lim, nav_lim, jump_lim, del_lim;
        r = int'($urandom_range(0, 99));
        case (mix)
            MIX_FILL:  begin c_lim = 80; nav_lim = 88; jump_lim = 92; del_lim = 97; end
            MIX_DRAIN: begin c_lim = 20; nav_lim = 35; jump_lim = 45; del_lim = 95; end
            default:   begin c_lim = 40; nav_lim = 70; jump_lim = 78; del_lim = 92; end
        endcase
        if (r < c_lim)
            return random_char();
        if (r < nav_lim)
            return $urandom_range(0, 1) ? KEY_RIGHT : KEY_LEFT;
        if (r < jump_lim)
            return $urandom_range(0, 1) ? KEY_HOME : KEY_END;
        if (r < del_lim)
            return $urandom_range(0, 1) ? KEY_DELETE : KEY_BACKSPACE;
        return KEY_ENTER;
    endfunction

    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = int'($urandom_range(0, 99));
        if (r < 50)
            return 0;
        if (r < 85)
            return int'($urandom_range(1, 3));
        if (r < 97)
            return int'($urandom_range(4, 12));
        return int'($urandom_range(20, 60));
    endfunction

    // Drop the cell at pos and close the gap; the vacated top cell reads zero.
    function automatic void drop_cell(int pos);
        for (int i = pos; i + 1 < line_len; i++)
            line_cells[i] = line_cells[i+1];
        line_cells[line_len-1] = '0;
        line_len--;
    endfunction

    function automatic line_res_t edit_line(logic [CHAR_W-1:0] k);
        line_res_t r;
        r.finished = 1'b0;
        case (k)
            KEY_RIGHT:     if (edit_cursor < line_len) edit_cursor++;
            KEY_LEFT:      if (edit_cursor > 0) edit_cursor--;
            KEY_HOME:      edit_cursor = 0;
            KEY_END:       edit_cursor = line_len;
            KEY_DELETE:    if (edit_cursor < line_len) drop_cell(edit_cursor);
            KEY_BACKSPACE:
                if (edit_cursor > 0)
                begin
                    edit_cursor--;
                    drop_cell(edit_cursor);
                end
            KEY_ENTER:     r.finished = 1'b1;
            default:
                // full means length reached LINE_SIZE-1, overwrites included
                if (line_len + 1 < LINE_CELLS && edit_cursor < LINE_CELLS)
                begin
                    line_cells[edit_cursor] = k;
                    if (edit_cursor >= line_len)
                        line_len++;
                    edit_cursor++;
                end
        endcase
        r.cursor_pos     = 7'(edit_cursor);
        r.line_length    = 7'(line_len);
        r.char_at_cursor = (edit_cursor < line_len) ? line_cells[edit_cursor] : '0;
        return r;
    endfunction

    task automatic report_bad(string what, bit has_want, line_res_t want, line_res_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            if (has_want)
                $display("%0t %s: exp cur=%0d len=%0d ch=%02h fin=%b, got cur=%0d len=%0d ch=%02h fin=%b",
                         $time, what, want.cursor_pos, want.line_length,
                         want.char_at_cursor, want.finished, got.cursor_pos,
                         got.line_length, got.char_at_cursor, got.finished);
            else
                $display("%0t %s: got cur=%0d len=%0d ch=%02h fin=%b", $time, what,
                         got.cursor_pos, got.line_length, got.char_at_cursor, got.finished);
        end
    endtask

    initial begin
        rst_n <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Key sender: builds the whole plan, then offers it with random gaps.
    initial begin
        key_row_t directed_rows [24];
        key_mix_t mix;
        int       r, burst, gap;
        bit       quiet;
        key_ch.valid    <= 1'b0;
        key_ch.key_code <= '0;
        quiet = 1'b0;
        directed_rows = '{
            mk_row(KEY_LEFT,      1'b1, 7'd0, 7'd0, 8'h00, 1'b0),
            mk_row(KEY_BACKSPACE, 1'b1, 7'd0, 7'd0, 8'h00, 1'b0),
            mk_row(KEY_RIGHT,     1'b1, 7'd0, 7'd0, 8'h00, 1'b0),
            mk_row(KEY_DELETE,    1'b1, 7'd0, 7'd0, 8'h00, 1'b0),
            mk_row(KEY_HOME,      1'b1, 7'd0, 7'd0, 8'h00, 1'b0),
            mk_row(KEY_END,       1'b1, 7'd0, 7'd0, 8'h00, 1'b0),
            mk_row(KEY_ENTER,     1'b1, 7'd0, 7'd0, 8'h00, 1'b1),
            mk_row(8'h00,         1'b1, 7'd1, 7'd1, 8'h00, 1'b0),
            mk_row(8'hFF,         1'b1, 7'd2, 7'd2, 8'h00, 1'b0),
            mk_row(KEY_UP,        1'b1, 7'd3, 7'd3, 8'h00, 1'b0),
            mk_row(8'h80,         1'b1, 7'd4, 7'd4, 8'h00, 1'b0),
            mk_row(KEY_HOME,      1'b1, 7'd0, 7'd4, 8'h00, 1'b0),
            mk_row(KEY_RIGHT,     1'b1, 7'd1, 7'd4, 8'hFF, 1'b0),
            mk_row(KEY_END,       1'b1, 7'd4, 7'd4, 8'h00, 1'b0),
            mk_row(KEY_LEFT,      1'b0, 7'd0, 7'd0, 8'h00, 1'b0),
            mk_row(8'h7E,         1'b0, 7'd0, 7'd0, 8'h00, 1'b0),
            mk_row(KEY_HOME,      1'b0, 7'd0, 7'd0, 8'h00, 1'b0),
            mk_row(KEY_DELETE,    1'b0, 7'd0, 7'd0, 8'h00, 1'b0),
            mk_row(KEY_RIGHT,     1'b0, 7'd0, 7'd0, 8'h00, 1'b0),
            mk_row(KEY_BACKSPACE, 1'b0, 7'd0, 7'd0, 8'h00, 1'b0),
            mk_row(KEY_ENTER,     1'b0, 7'd0, 7'd0, 8'h00, 1'b0),
            mk_row(8'h01,         1'b0, 7'd0, 7'd0, 8'h00, 1'b0),
            mk_row(KEY_END,       1'b0, 7'd0, 7'd0, 8'h00, 1'b0),
            mk_row(KEY_BACKSPACE, 1'b0, 7'd0, 7'd0, 8'h00, 1'b0)
        };
        for (int d = 0; d < 24; d++)
            key_plan.push_back(directed_rows[d]);
        // run straight into the full buffer first, then random bursts
        for (int n = 0; n < FILL_KEYS; n++)
            key_plan.push_back(mk_row(random_char(), 1'b0, 7'd0, 7'd0, 8'h00, 1'b0));
        while (key_plan.size() < 24 + RANDOM_KEYS)
        begin
            r = int'($urandom_range(0, 9));
            mix = (r < 4) ? MIX_FILL : (r < 6) ? MIX_DRAIN : MIX_MIXED;
            burst = int'($urandom_range(20, 120));
            repeat (burst)
                key_plan.push_back(mk_row(pick_key(mix), 1'b0, 7'd0, 7'd0, 8'h00, 1'b0));
        end
        plan_built = 1'b1;

        wait (rst_n === 1'b1);
        @(posedge clk);
        for (int i = 0; i < key_plan.size(); i++)
        begin
            if (i % 50 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            gap = pick_gap(quiet);
            // valid stays high across back-to-back transactions
            if (gap > 0)
            begin
                key_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            key_ch.valid    <= 1'b1;
            key_ch.key_code <= key_plan[i].key;
            @(posedge clk);
            while (!key_ch.ready)
                @(posedge clk);
        end
        key_ch.valid <= 1'b0;
    end

    // Result receiver: random stalls plus one long hold-off to back up the input.
    initial begin
        int hold, loops;
        bit quiet, pressed;
        res_ch.ready <= 1'b0;
        loops   = 0;
        quiet   = 1'b0;
        pressed = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (loops % 40 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            loops++;
            if (!pressed && results_seen >= 300)
            begin
                pressed = 1'b1;
                hold    = 400;
            end
            else
                hold = pick_gap(quiet);
            if (hold > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        line_res_t want, got;
        key_row_t  row;
        if (rst_n)
        begin
            if (key_ch.valid && key_ch.ready)
            begin
                row  = key_plan[keys_accepted];
                want = edit_line(row.key);
                if (row.fixed)
                    want = row.res;
                pending_q.push_back(want);
                keys_accepted++;
            end
            if (res_ch.valid && res_ch.ready)
            begin
                got.cursor_pos     = res_ch.cursor_pos;
                got.line_length    = res_ch.line_length;
                got.char_at_cursor = res_ch.char_at_cursor;
                got.finished       = res_ch.finished;
                results_seen++;
                if (pending_q.size() == 0)
                    report_bad("unexpected result", 1'b0, got, got);
                else
                begin
                    want = pending_q.pop_front();
                    if (got !== want)
                        report_bad("result mismatch", 1'b1, want, got);
                end
            end
        end
    end

    initial begin
        wait (rst_n === 1'b1);
        while (!(plan_built && keys_accepted == key_plan.size() && pending_q.size() == 0))
            @(posedge clk);
        // extra wait covers a home/end walk across the whole line
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && pending_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/leb_pkg.sv
hw/rtl/leb_if.sv
hw/rtl/leb_cell.sv
hw/rtl/leb_stack.sv
hw/rtl/line_edit_buffer_unit.sv
bench/testbench.sv
